// ===== hw/rtl/brb_pkg.sv =====
// Shared types and constants for the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package brb_pkg;

  localparam int DEPTH_DEF = 4096;  // default number of byte slots
  localparam int CAP_RESET = 4096;  // capacity register value after reset
  localparam int CAP_W     = 13;
  localparam int OPC_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int OFF_W     = 12;
  localparam int STAT_W    = 2;
  localparam int FILL_W    = 13;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_REWIND = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic exec;       // perform the operation, update positions and count
    logic step;       // one step of the peek address remainder
    logic read_rem;   // read the store at the reduced peek address
    logic load_out;   // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_reduce;  // peek address still at or above the store depth
    logic reduce_last;  // final reduction step
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/brb_ctrl.sv =====
// Sequencing state machine for the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
module brb_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire brb_pkg::sts_t sts_i,
  output brb_pkg::cmd_t     cmd_o
);
  import brb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_REDUCE = 5'b00100,
    S_READ   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.need_reduce ? S_REDUCE : S_DONE;
      end
      S_REDUCE: begin
        cmd_o.step = 1'b1;
        if (sts_i.reduce_last) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.read_rem = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/brb_dp.sv =====
// Datapath of the byte ring buffer: store, positions, count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module brb_dp #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [brb_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  wire logic [brb_pkg::OPC_W-1:0]   opcode_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]  push_byte_i,
  input  wire logic [brb_pkg::OFF_W-1:0]   peek_offset_i,
  input  wire brb_pkg::cmd_t               cmd_i,
  output brb_pkg::sts_t                    sts_o,
  output logic [brb_pkg::BYTE_W-1:0]       read_byte_o,
  output logic [brb_pkg::STAT_W-1:0]       status_o,
  output logic [brb_pkg::FILL_W-1:0]       fill_count_o,
  output logic                             became_full_o,
  output logic                             left_full_o
);
  import brb_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 1;
  localparam int PROD_W = 2 * SUM_W;
  localparam int CAP_RST_I = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
  localparam logic [CNT_W-1:0]  CAP_RST = CNT_W'(CAP_RST_I);
  localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(DEPTH);
  // floor(2^SUM_W / DEPTH): quotient estimate is exact or one low
  localparam logic [SUM_W-1:0]  RECIP   = SUM_W'((1 << SUM_W) / DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];

  // state
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cap_q, cap_d;

  // latched transaction
  op_e               op_q;
  logic [BYTE_W-1:0] pb_q;
  logic [OFF_W-1:0]  off_q;

  // peek reduction unit: quotient by reciprocal multiply, then subtract
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic              step_q, step_d;
  logic [PROD_W-1:0] quo_prod;
  logic [SUM_W-1:0]  rem_fix;

  // result staging
  stat_e             res_st_q, res_st_d;
  logic              res_bf_q, res_bf_d, res_lf_q, res_lf_d, res_rd_q, res_rd_d;
  logic [BYTE_W-1:0] rdata_q;

  logic             we, re;
  logic [PTR_W-1:0] raddr;
  logic [CNT_W-1:0] cap_eff, wp_inc, rp_inc, cnt_inc;
  logic [SUM_W-1:0] peek_sum, peek_wrap;
  logic             is_full, is_empty;

  assign cap_eff = ((cfg_wdata_i == '0) || (32'(cfg_wdata_i) > 32'(DEPTH)))
                   ? CNT_W'(DEPTH) : CNT_W'(cfg_wdata_i);

  assign is_full  = (cnt_q >= cap_q);
  assign is_empty = (cnt_q == '0);
  assign wp_inc   = CNT_W'(wp_q) + CNT_W'(1);
  assign rp_inc   = CNT_W'(rp_q) + CNT_W'(1);
  assign cnt_inc  = cnt_q + CNT_W'(1);

  assign peek_sum  = SUM_W'(rp_q) + SUM_W'(off_q);
  assign peek_wrap = (peek_sum >= SUM_W'(cap_q)) ? (peek_sum - SUM_W'(cap_q)) : peek_sum;

  assign quo_prod = PROD_W'(rem_q) * PROD_W'(RECIP);
  assign rem_fix  = (rem_q >= DEPTH_S) ? (rem_q - DEPTH_S) : rem_q;

  assign sts_o.need_reduce = (op_q == OP_PEEK) && (peek_wrap >= DEPTH_S);
  assign sts_o.reduce_last = step_q;

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    cnt_d    = cnt_q;
    cap_d    = cap_q;
    res_st_d = res_st_q;
    res_bf_d = res_bf_q;
    res_lf_d = res_lf_q;
    res_rd_d = res_rd_q;
    we       = 1'b0;
    re       = 1'b0;
    raddr    = rp_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;

    if (cfg_we_i) begin
      cap_d = cap_eff;
      wp_d  = '0;
      rp_d  = '0;
      cnt_d = '0;
    end else if (cmd_i.exec) begin
      res_st_d = ST_DONE;
      res_bf_d = 1'b0;
      res_lf_d = 1'b0;
      res_rd_d = 1'b0;
      rem_d    = peek_wrap;
      step_d   = 1'b0;
      unique case (op_q)
        OP_PUSH: begin
          if (is_full) begin
            res_st_d = ST_FULL;
          end else begin
            we       = 1'b1;
            wp_d     = (wp_inc >= cap_q) ? '0 : PTR_W'(wp_inc);
            cnt_d    = cnt_inc;
            res_bf_d = (cnt_inc == cap_q);
          end
        end
        OP_POP: begin
          if (is_empty) begin
            res_st_d = ST_EMPTY;
          end else begin
            re       = 1'b1;
            raddr    = rp_q;
            res_rd_d = 1'b1;
            res_lf_d = (cnt_q == cap_q);
            rp_d     = (rp_inc >= cap_q) ? '0 : PTR_W'(rp_inc);
            cnt_d    = cnt_q - CNT_W'(1);
          end
        end
        OP_PEEK: begin
          res_rd_d = 1'b1;
          // addresses past the store depth take the reduction path first
          if (peek_wrap < DEPTH_S) begin
            re    = 1'b1;
            raddr = PTR_W'(peek_wrap);
          end
        end
        OP_REWIND: begin
          if (is_empty) begin
            wp_d = '0;
            rp_d = '0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      if (!step_q) begin
        quo_d  = quo_prod[PROD_W-1:SUM_W];
        step_d = 1'b1;
      end else begin
        // leaves a remainder below 2*DEPTH; the read folds the last DEPTH
        rem_d = rem_q - quo_q * DEPTH_S;
      end
    end else if (cmd_i.read_rem) begin
      re    = 1'b1;
      raddr = PTR_W'(rem_fix);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      cap_q <= CAP_RST;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
      cap_q <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      pb_q  <= push_byte_i;
      off_q <= peek_offset_i;
    end
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
    res_st_q <= res_st_d;
    res_bf_q <= res_bf_d;
    res_lf_q <= res_lf_d;
    res_rd_q <= res_rd_d;
    if (cmd_i.load_out) begin
      read_byte_o   <= res_rd_q ? rdata_q : '0;
      status_o      <= res_st_q;
      fill_count_o  <= FILL_W'(cnt_q);
      became_full_o <= res_bf_q;
      left_full_o   <= res_lf_q;
    end
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[wp_q] <= pb_q;
    if (re) rdata_q <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the input transaction is accepted, executed, and its result loaded
//   into the output register; a peek whose wrapped address is still at or above
//   DEPTH first takes the remainder by DEPTH (quotient step, subtract step) and a
//   store read. The result load waits while the output register is still full,
//   and a new transaction is accepted only after the previous result is loaded.
// Reset: positions and fill count go to zero, capacity to min(4096, DEPTH);
//   the byte store is not cleared.
module byte_ring_buffer #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // capacity register write; also empties the FIFO
  input  wire logic                        cfg_we_i,
  input  wire logic [brb_pkg::CAP_W-1:0]   cfg_wdata_i,
  // operation channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [brb_pkg::OPC_W-1:0]   opcode_i,
  input  wire logic [brb_pkg::BYTE_W-1:0]  push_byte_i,
  input  wire logic [brb_pkg::OFF_W-1:0]   peek_offset_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [brb_pkg::BYTE_W-1:0]       read_byte_o,
  output logic [brb_pkg::STAT_W-1:0]       status_o,
  output logic [brb_pkg::FILL_W-1:0]       fill_count_o,
  output logic                             became_full_o,
  output logic                             left_full_o
);
  import brb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller takes a new transaction only from idle; the result sits in
  // the datapath output register, so a pending result does not block input.
  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath owns the store, positions, count, capacity and the peek
  // address reduction (reciprocal-multiply remainder by DEPTH).
  brb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .push_byte_i   (push_byte_i),
    .peek_offset_i (peek_offset_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .read_byte_o   (read_byte_o),
    .status_o      (status_o),
    .fill_count_o  (fill_count_o),
    .became_full_o (became_full_o),
    .left_full_o   (left_full_o)
  );

endmodule
`default_nettype wire

// ===== tb/byte_ring_buffer_tb.sv =====
// Self-checking testbench for the byte ring buffer: shadow FIFO, random traffic and stalls.
`timescale 1ns / 1ps
module byte_ring_buffer_tb;
  import brb_pkg::*;

  localparam int DRAIN_CYCLES = 24;       // covers accept/execute/load plus a long peek
  localparam int PHASE_ITEMS  = 210;
  localparam int NUM_PHASES   = 8;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct {
    logic [BYTE_W-1:0] rbyte;
    stat_e             status;
    logic [FILL_W-1:0] fill;
    logic              became_full;
    logic              left_full;
  } ring_result_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIX} fill_bias_e;

  // Shadow copy of the FIFO: tracks positions, count and store contents, and
  // queues the result each accepted operation should produce.
  class ring_shadow;
    logic [BYTE_W-1:0] slots [DEPTH_DEF];
    bit                written [DEPTH_DEF];
    int unsigned       wr_pos;
    int unsigned       rd_pos;
    int unsigned       held;
    int unsigned       cap_reg;
    int unsigned       err_count;
    ring_result_t      pending_results[$];

    function new();
      cap_reg = CAP_RESET;
    endfunction

    // zero and anything past the store both mean "all slots"
    function int unsigned eff_cap();
      if (cap_reg == 0 || cap_reg > DEPTH_DEF) return DEPTH_DEF;
      return cap_reg;
    endfunction

    function void write_capacity(logic [CAP_W-1:0] value);
      cap_reg = 32'(value);
      wr_pos  = 0;
      rd_pos  = 0;
      held    = 0;
    endfunction

    // one wrap by capacity, then whatever is left folds into the store
    function int unsigned peek_slot(logic [OFF_W-1:0] off);
      int unsigned p;
      p = rd_pos + off;
      if (p >= eff_cap()) p -= eff_cap();
      return p % DEPTH_DEF;
    endfunction

    function void note_op(op_e op, logic [BYTE_W-1:0] pb, logic [OFF_W-1:0] off);
      ring_result_t r;
      int unsigned  c;
      c             = eff_cap();
      r.rbyte       = '0;
      r.status      = ST_DONE;
      r.became_full = 1'b0;
      r.left_full   = 1'b0;
      case (op)
        OP_PUSH: begin
          if (held >= c) begin
            r.status = ST_FULL;
          end else begin
            slots[wr_pos]   = pb;
            written[wr_pos] = 1'b1;
            wr_pos          = (wr_pos + 1 >= c) ? 0 : wr_pos + 1;
            held++;
            r.became_full   = (held == c);
          end
        end
        OP_POP: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.rbyte     = slots[rd_pos];
            r.left_full = (held == c);
            rd_pos      = (rd_pos + 1 >= c) ? 0 : rd_pos + 1;
            held--;
          end
        end
        OP_PEEK: begin
          r.rbyte = slots[peek_slot(off)];
        end
        default: begin
          // rewind only takes effect on an empty store
          if (held == 0) begin
            wr_pos = 0;
            rd_pos = 0;
          end
        end
      endcase
      r.fill = FILL_W'(held);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [BYTE_W-1:0] rb, logic [STAT_W-1:0] st,
                               logic [FILL_W-1:0] fc, logic bf, logic lf);
      ring_result_t e;
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: read_byte %0d status %0d fill %0d",
               rb, st, fc);
        err_count++;
        return;
      end
      e = pending_results.pop_front();
      if (rb !== e.rbyte) begin
        $error("read_byte: expected %0d, got %0d", e.rbyte, rb);
        err_count++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        err_count++;
      end
      if (fc !== e.fill) begin
        $error("fill_count: expected %0d, got %0d", e.fill, fc);
        err_count++;
      end
      if (bf !== e.became_full) begin
        $error("became_full: expected %0d, got %0d", e.became_full, bf);
        err_count++;
      end
      if (lf !== e.left_full) begin
        $error("left_full: expected %0d, got %0d", e.left_full, lf);
        err_count++;
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [OPC_W-1:0]    opcode_i      = OP_PUSH;
  logic [BYTE_W-1:0]   push_byte_i   = '0;
  logic [OFF_W-1:0]    peek_offset_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [BYTE_W-1:0]   read_byte_o;
  logic [STAT_W-1:0]   status_o;
  logic [FILL_W-1:0]   fill_count_o;
  logic                became_full_o;
  logic                left_full_o;

  ring_shadow  sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  byte_ring_buffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .push_byte_i  (push_byte_i),
    .peek_offset_i(peek_offset_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_byte_o  (read_byte_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o),
    .became_full_o(became_full_o),
    .left_full_o  (left_full_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: values seen here are the ones from before the edge, so a
  // transaction is exactly valid && ready as sampled. Ready is then redrawn.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(read_byte_o, status_o, fill_count_o, became_full_o, left_full_o);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one operation and returns at the edge where it is taken. The
  // shadow is updated there, so the next choice sees the current state.
  task automatic drive_op(op_e op, logic [BYTE_W-1:0] pb, logic [OFF_W-1:0] off);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    push_byte_i   <= pb;
    peek_offset_i <= off;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_op(op, pb, off);
  endtask

  // Capacity writes land only on an idle block; the write also empties the FIFO.
  task automatic set_capacity(logic [CAP_W-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_capacity(value);
  endtask

  // Peeks must land on a slot written since reset. Offsets below the fill
  // count are always safe; fully random ones are kept only if they hit one.
  function automatic bit pick_peek_offset(output logic [OFF_W-1:0] off);
    logic [OFF_W-1:0] cand;
    for (int t = 0; t < 24; t++) begin
      if (sb.held != 0 && $urandom_range(1)) cand = OFF_W'($urandom_range(sb.held - 1));
      else cand = OFF_W'($urandom_range(4095));
      if (sb.written[sb.peek_slot(cand)]) begin
        off = cand;
        return 1'b1;
      end
    end
    off = '0;
    return 1'b0;
  endfunction

  // Random traffic in bursts that lean toward filling, draining or neither,
  // so small capacities swing between full and empty many times.
  task automatic run_random(int unsigned n);
    fill_bias_e        bias;
    int unsigned       burst_left;
    int unsigned       pick;
    int unsigned       push_pct;
    op_e               op;
    logic [BYTE_W-1:0] pb;
    logic [OFF_W-1:0]  off;
    burst_left = 0;
    bias       = BIAS_MIX;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        bias       = fill_bias_e'($urandom_range(2));
        burst_left = $urandom_range(6, 48);
      end
      burst_left--;
      pb   = BYTE_W'($urandom_range(255));
      off  = OFF_W'($urandom_range(4095));
      pick = $urandom_range(99);
      case (bias)
        BIAS_FILL:  push_pct = 75;
        BIAS_DRAIN: push_pct = 25;
        default:    push_pct = 50;
      endcase
      if (pick < 8) begin
        op = OP_REWIND;
      end else if (pick < 28) begin
        op = OP_PEEK;
        if (!pick_peek_offset(off)) op = OP_POP;
      end else begin
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      end
      drive_op(op, pb, off);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap_val;
    idle_mode_e       mode;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, capacity at its reset value: empty pop, rewind both ways,
    // extreme bytes, a peek whose offset wraps past capacity.
    drive_op(OP_POP,    8'h00, 12'h000);
    drive_op(OP_REWIND, 8'h00, 12'h000);
    drive_op(OP_PUSH,   8'h00, 12'h000);
    drive_op(OP_PUSH,   8'hFF, 12'h000);
    drive_op(OP_PUSH,   8'hA5, 12'h000);
    drive_op(OP_PEEK,   8'h00, 12'h000);
    drive_op(OP_PEEK,   8'h00, 12'h002);
    drive_op(OP_POP,    8'h00, 12'h000);
    drive_op(OP_POP,    8'h00, 12'h000);
    drive_op(OP_REWIND, 8'h00, 12'h000);   // not empty: positions stay
    drive_op(OP_PEEK,   8'h00, 12'hFFF);   // wraps back to slot 1
    drive_op(OP_POP,    8'h00, 12'h000);
    drive_op(OP_REWIND, 8'h00, 12'h000);
    drive_op(OP_PUSH,   8'h5A, 12'h000);
    drive_op(OP_POP,    8'h00, 12'h000);

    // Two slots: fill, refused push, peek past capacity, pop from full.
    set_capacity(13'd2);
    drive_op(OP_PUSH, 8'h81, 12'h000);
    drive_op(OP_PUSH, 8'h7E, 12'h000);
    drive_op(OP_PUSH, 8'h33, 12'h000);
    drive_op(OP_PEEK, 8'h00, 12'h003);
    drive_op(OP_POP,  8'h00, 12'h000);
    drive_op(OP_PUSH, 8'hC3, 12'h000);
    drive_op(OP_POP,  8'h00, 12'h000);
    drive_op(OP_POP,  8'h00, 12'h000);
    drive_op(OP_POP,  8'h00, 12'h000);

    // Random phases: each sets a capacity and an idle/stall pattern.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       cap_val = 13'd3;
        1:       cap_val = 13'd1;
        2:       cap_val = 13'd0;      // means all slots
        3:       cap_val = 13'd4096;
        4:       cap_val = 13'd8191;   // saturates to the store size
        5:       cap_val = CAP_W'($urandom_range(2, 16));
        6:       cap_val = CAP_W'($urandom_range(17, 300));
        default: cap_val = CAP_W'($urandom_range(0, 8191));
      endcase
      set_capacity(cap_val);
      mode = idle_mode_e'(ph % 4);
      case (mode)
        IDLE_SEND: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
        end
        IDLE_BOTH: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_random(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== byte_ring_buffer.f =====
hw/rtl/brb_pkg.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_dp.sv
hw/rtl/byte_ring_buffer.sv
tb/byte_ring_buffer_tb.sv
